>>> hdl/savg_pkg.sv
// ----------------------------------------------------------------------------
// savg_pkg: shared types and constants
// Sample and result beat types, filter geometry and the tap table (Q1.17 scale, stored in 14 signed bits).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package savg_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int HALF_W     = 19;
  localparam int TAPS       = 2 * HALF_W + 1;
  localparam int COEF_FRAC  = 17;
  localparam int COEF_W     = 14;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int TREE_LVLS  = 6;
  localparam int TREE_LEAVES = 1 << TREE_LVLS;
  localparam int ACC_W      = PROD_W + TREE_LVLS;
  localparam int CNT_W      = $clog2(HALF_W + 2);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last_res;
    logic                       short_error;
  } out_beat_t;

  // Control tag that travels beside the datapath
  typedef struct packed {
    logic vld;
    logic last;
    logic err;
  } tag_t;

  // Coefficient for tap offset |k|, Q1.17 scale stored in 14 signed bits
  function automatic logic signed [COEF_W-1:0] coef_at(input int k);
    logic signed [COEF_W-1:0] c;
    case (k)
      0:       c = 14'sd7570;
      1:       c = 14'sd7537;
      2:       c = 14'sd7437;
      3:       c = 14'sd7271;
      4:       c = 14'sd7038;
      5:       c = 14'sd6739;
      6:       c = 14'sd6374;
      7:       c = 14'sd5942;
      8:       c = 14'sd5443;
      9:       c = 14'sd4878;
      10:      c = 14'sd4247;
      11:      c = 14'sd3549;
      12:      c = 14'sd2785;
      13:      c = 14'sd1954;
      14:      c = 14'sd1057;
      15:      c = 14'sd93;
      16:      c = -14'sd937;
      17:      c = -14'sd2034;
      18:      c = -14'sd3197;
      19:      c = -14'sd4426;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/savg_fir_mirror_boundary_core.sv
// ----------------------------------------------------------------------------
// savgol_fir_mirror_boundary_core: 39-tap smoothing FIR, mirror boundary
// A row of window cells feeds a registered adder tree; round and saturate.
// ----------------------------------------------------------------------------
//  channel | dir | beat      | accepted when
//  in_     | in  | in_beat_t | in_valid  && !in_stall
//  out_    | out | out_beat_t| out_valid && !out_stall
//
//  One sample per cycle while streaming and the output is not stalled; the
//  last sample holds the input off while reflected samples shift through
//  the cells. Results pass the product register, six tree levels and the
//  output register after their step. A stalled output freezes the whole
//  row and tree; reset clears counts, drain state and valid tags only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module savgol_fir_mirror_boundary_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire savg_pkg::in_beat_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output savg_pkg::out_beat_t       out_data
);
  import savg_pkg::*;

  localparam logic signed [ACC_W:0] HI = (ACC_W+1)'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W:0] LO = -HI - 1;
  localparam logic signed [ACC_W:0] HALF_LSB = (ACC_W+1)'(64'sd1 <<< (COEF_FRAC - 1));

  logic adv, in_acc, step, prime, short_last;
  logic drain_r, drain_nxt;
  logic [CNT_W-1:0] seen_r, seen_nxt, cnt_r, cnt_nxt;
  logic signed [SAMPLE_W-1:0] shift_in;
  logic signed [SAMPLE_W-1:0] win_d [TAPS];
  logic signed [SAMPLE_W-1:0] win_q [TAPS];
  logic signed [PROD_W-1:0]   prod  [TAPS];
  logic signed [ACC_W-1:0]    sum;
  logic signed [ACC_W:0]      rnd;
  tag_t tag_r, tag_nxt;
  tag_t tag_p_r [TREE_LVLS+1];
  logic out_valid_r;
  out_beat_t out_r, out_nxt;

  // Handshake: the whole row advances when the output can move
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv || drain_r;
  assign in_acc   = in_valid && !in_stall;
  assign step     = in_acc || (drain_r && adv);
  assign prime    = in_acc && (seen_r == CNT_W'(HALF_W));
  assign short_last = in_acc && in_data.last && (seen_r < CNT_W'(HALF_W));

  // Pick the reflected sample during drain
  always_comb begin
    shift_in = in_data.sample;
    if (drain_r) begin
      for (int m = 1; m <= HALF_W; m++) begin
        if (cnt_r == CNT_W'(m)) begin
          shift_in = win_q[2*m-1];
        end
      end
    end
  end

  // Shift the window; on priming load the left mirror into the far half
  always_comb begin
    win_d[0] = shift_in;
    for (int j = 1; j < TAPS; j++) begin
      win_d[j] = win_q[j-1];
    end
    if (prime) begin
      for (int j = HALF_W + 1; j < TAPS - 1; j++) begin
        win_d[j] = win_q[TAPS-2-j];
      end
      win_d[TAPS-1] = shift_in;
    end
  end

  for (genvar j = 0; j < TAPS; j++) begin : g_cell
    savg_cell #(.TAP(j)) u_cell (
      .clk  (clk),
      .ld   (step),
      .adv  (adv),
      .d    (win_d[j]),
      .q    (win_q[j]),
      .prod (prod[j])
    );
  end

  savg_tree u_tree (
    .clk  (clk),
    .adv  (adv),
    .prod (prod),
    .sum  (sum)
  );

  // Count samples and run the drain
  always_comb begin
    seen_nxt  = seen_r;
    drain_nxt = drain_r;
    cnt_nxt   = cnt_r;
    if (in_acc) begin
      if (in_data.last) begin
        seen_nxt = '0;
        if (!short_last) begin
          drain_nxt = 1'b1;
          cnt_nxt   = CNT_W'(1);
        end
      end else if (seen_r < CNT_W'(HALF_W + 1)) begin
        seen_nxt = seen_r + CNT_W'(1);
      end
    end else if (drain_r && adv) begin
      if (cnt_r == CNT_W'(HALF_W)) begin
        drain_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  // Tag the beat produced by this step
  always_comb begin
    tag_nxt = '0;
    if (drain_r) begin
      tag_nxt.vld  = 1'b1;
      tag_nxt.last = (cnt_r == CNT_W'(HALF_W));
    end else if (in_acc) begin
      tag_nxt.vld  = in_data.last || (seen_r >= CNT_W'(HALF_W));
      tag_nxt.last = short_last;
      tag_nxt.err  = short_last;
    end
  end

  // Round to nearest and saturate; a short-error beat carries zero
  always_comb begin
    rnd = ((ACC_W+1)'(sum) + HALF_LSB) >>> COEF_FRAC;
    out_nxt.last_res    = tag_p_r[TREE_LVLS].last;
    out_nxt.short_error = tag_p_r[TREE_LVLS].err;
    if (tag_p_r[TREE_LVLS].err) begin
      out_nxt.value = '0;
    end else if (rnd > HI) begin
      out_nxt.value = HI[SAMPLE_W-1:0];
    end else if (rnd < LO) begin
      out_nxt.value = LO[SAMPLE_W-1:0];
    end else begin
      out_nxt.value = rnd[SAMPLE_W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      drain_r     <= 1'b0;
      cnt_r       <= '0;
      tag_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i <= TREE_LVLS; i++) begin
        tag_p_r[i] <= '0;
      end
    end else begin
      seen_r  <= seen_nxt;
      drain_r <= drain_nxt;
      cnt_r   <= cnt_nxt;
      if (adv) begin
        tag_r      <= step ? tag_nxt : '0;
        tag_p_r[0] <= tag_r;
        for (int i = 1; i <= TREE_LVLS; i++) begin
          tag_p_r[i] <= tag_p_r[i-1];
        end
        out_valid_r <= tag_p_r[TREE_LVLS].vld;
      end
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.short_error |-> out_data.last_res && out_data.value == '0)
    else $error("short error beat carries data");

  a_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> in_stall)
    else $error("input taken during drain");

  a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= CNT_W'(HALF_W + 1))
    else $error("sample count out of range");

  a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> cnt_r >= CNT_W'(1) && cnt_r <= CNT_W'(HALF_W))
    else $error("drain counter out of range");

endmodule

`default_nettype wire

>>> hdl/savg_cell.sv
// ----------------------------------------------------------------------------
// savg_cell: one window cell
// Holds one sample of the window and registers its weighted product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module savg_cell #(
  parameter int TAP = 0
) (
  input  wire logic                                  clk,
  input  wire logic                                  ld,
  input  wire logic                                  adv,
  input  wire logic signed [savg_pkg::SAMPLE_W-1:0]  d,
  output logic signed [savg_pkg::SAMPLE_W-1:0]       q,
  output logic signed [savg_pkg::PROD_W-1:0]         prod
);
  import savg_pkg::*;

  localparam int OFS = (HALF_W - TAP < 0) ? TAP - HALF_W : HALF_W - TAP;
  localparam logic signed [COEF_W-1:0] CF = coef_at(OFS);

  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [PROD_W-1:0]   prod_r;

  // Load the incoming window sample on a step
  always_ff @(posedge clk) begin
    if (ld) begin
      sample_r <= d;
    end
  end

  // Weight the held sample
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= PROD_W'(sample_r) * PROD_W'(CF);
    end
  end

  assign q    = sample_r;
  assign prod = prod_r;

endmodule

`default_nettype wire

>>> hdl/savg_tree.sv
// ----------------------------------------------------------------------------
// savg_tree: registered adder tree
// Sums the cell products in pairs, one register level per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module savg_tree (
  input  wire logic                                clk,
  input  wire logic                                adv,
  input  wire logic signed [savg_pkg::PROD_W-1:0]  prod [savg_pkg::TAPS],
  output logic signed [savg_pkg::ACC_W-1:0]        sum
);
  import savg_pkg::*;

  logic signed [ACC_W-1:0] leaf [TREE_LEAVES];

  // Pad the leaf row with zeros
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      leaf[i] = ACC_W'(prod[i]);
    end
    for (int i = TAPS; i < TREE_LEAVES; i++) begin
      leaf[i] = '0;
    end
  end

  for (genvar g = 0; g < TREE_LVLS; g++) begin : g_lvl
    localparam int CNT = TREE_LEAVES >> (g + 1);
    logic signed [ACC_W-1:0] s_r [CNT];
    for (genvar i = 0; i < CNT; i++) begin : g_node
      if (g == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (adv) begin
            s_r[i] <= leaf[2*i] + leaf[2*i+1];
          end
        end
      end else begin : g_rest
        always_ff @(posedge clk) begin
          if (adv) begin
            s_r[i] <= g_lvl[g-1].s_r[2*i] + g_lvl[g-1].s_r[2*i+1];
          end
        end
      end
    end
  end

  assign sum = g_lvl[TREE_LVLS-1].s_r[0];

endmodule

`default_nettype wire
